>>> hw/rtl/rpfa_pkg.sv
// Shared types and constants of the page frame allocator.
// Holds operation, status and configuration register codes, the sequencer
// states, the field widths and the result bundle. Depends on nothing.
package rpfa_pkg;

  localparam int PAGE_COUNT_DEF = 32768;
  localparam int COUNT_BITS_DEF = 8;

  localparam int KIND_W      = 2;
  localparam int PAGE_W      = 15;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 8;
  localparam int FIRST_W     = 15;
  localparam int END_W       = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INIT   = 2'd0,
    KIND_ALLOC  = 2'd1,
    KIND_FREE   = 2'd2,
    KIND_ADDREF = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_RANGE     = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_PAGE = 1'd0,
    CFG_END_PAGE   = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_POP,
    S_RMW,
    S_REPLY
  } state_t;

  typedef struct packed {
    status_t                  status;
    logic [PAGE_W-1:0]        page_out;
    logic                     released;
    logic [COUNT_OUT_W-1:0]   count_after;
  } result_t;

endpackage

>>> hw/rtl/rpfa_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that updates only when a read is issued.
// Used for both the reference count store and the free stack.
module rpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/rpfa_ctrl.sv
// Sequencer of the page frame allocator: configuration registers, stack
// depth, init sweep, read-modify-write of the counts and the result register.
// Depends on rpfa_pkg; drives the two rpfa_ram instances in the top level.
module rpfa_ctrl #(
  parameter int PAGE_COUNT = rpfa_pkg::PAGE_COUNT_DEF,
  parameter int COUNT_BITS = rpfa_pkg::COUNT_BITS_DEF,
  parameter int PB         = $clog2(PAGE_COUNT)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rpfa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [rpfa_pkg::KIND_W-1:0]       kind,
  input  logic [rpfa_pkg::PAGE_W-1:0]       page_number,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output rpfa_pkg::result_t                 rsp,
  output logic                              cnt_we,
  output logic [PB-1:0]                     cnt_waddr,
  output logic [COUNT_BITS-1:0]             cnt_wdata,
  output logic                              cnt_re,
  output logic [PB-1:0]                     cnt_raddr,
  input  logic [COUNT_BITS-1:0]             cnt_rdata,
  output logic                              stk_we,
  output logic [PB-1:0]                     stk_waddr,
  output logic [PB-1:0]                     stk_wdata,
  output logic                              stk_re,
  output logic [PB-1:0]                     stk_raddr,
  input  logic [PB-1:0]                     stk_rdata
);
  import rpfa_pkg::*;

  // Common compare width: holds end_page and PAGE_COUNT itself.
  localparam int CW  = (PB + 1 > END_W) ? PB + 1 : END_W;
  localparam int PXW = (PB > PAGE_W) ? PB : PAGE_W;
  localparam int CXW = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;

  localparam logic [CW-1:0]         PC_C      = CW'(PAGE_COUNT);
  localparam logic [PB:0]           DEPTH_MAX = (PB + 1)'(PAGE_COUNT);
  localparam logic [PB-1:0]         LAST_PAGE = PB'(PAGE_COUNT - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

  logic [FIRST_W-1:0] first_page;
  logic [END_W-1:0]   end_page;

  state_t          state, state_next;
  logic [PB:0]     depth, depth_next;
  logic [PB-1:0]   sweep, sweep_next;
  kind_t           op_kind;
  logic [PB-1:0]   op_idx;
  result_t         pend, pend_next;
  logic            pend_load;
  result_t         out_next;
  logic            out_load;
  logic            slot_free;

  logic [CW-1:0]   first_c, end_c, top_c, len_c, pg_c, sweep_c, stk_off;
  logic            in_range;
  logic [PB:0]     init_len;
  logic [PB-1:0]   pg_idx;
  logic [PXW-1:0]  got_x;
  logic [CXW-1:0]  cnt_x;
  logic [COUNT_BITS-1:0] cnt_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_page <= '0;
      end_page   <= 16'h8000;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FIRST_PAGE: first_page <= cfg_data[FIRST_W-1:0];
        CFG_END_PAGE:   end_page   <= cfg_data[END_W-1:0];
        default: ;
      endcase
    end
  end

  assign first_c  = CW'(first_page);
  assign end_c    = CW'(end_page);
  assign top_c    = (end_c < PC_C) ? end_c : PC_C;
  assign len_c    = (top_c > first_c) ? top_c - first_c : '0;
  assign init_len = len_c[PB:0];
  assign pg_c     = CW'(page_number);
  assign in_range = (pg_c >= first_c) && (pg_c < top_c);
  assign pg_idx   = pg_c[PB-1:0];
  assign sweep_c  = CW'(sweep);
  assign stk_off  = sweep_c - first_c;
  assign got_x    = PXW'(stk_rdata);

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    depth_next = depth;
    sweep_next = sweep;
    pend_next  = pend;
    pend_load  = 1'b0;
    out_next   = '{status: ST_OK, page_out: '0, released: 1'b0, count_after: '0};
    out_load   = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = sweep;
    cnt_wdata  = '0;
    cnt_re     = 1'b0;
    cnt_raddr  = pg_idx;
    stk_we     = 1'b0;
    stk_waddr  = stk_off[PB-1:0];
    stk_wdata  = sweep;
    stk_re     = 1'b0;
    stk_raddr  = depth[PB-1:0] - 1'b1;
    cnt_new    = cnt_rdata;
    cnt_x      = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (kind_t'(kind))
            KIND_INIT: begin
              sweep_next = '0;
              depth_next = init_len;
              state_next = S_SWEEP;
            end
            KIND_ALLOC: begin
              if (depth == '0) begin
                pend_next  = '{status: ST_OOM, page_out: '0, released: 1'b0,
                               count_after: '0};
                pend_load  = 1'b1;
                state_next = S_REPLY;
              end else begin
                stk_re     = 1'b1;
                depth_next = depth - 1'b1;
                state_next = S_POP;
              end
            end
            KIND_FREE, KIND_ADDREF: begin
              if (!in_range) begin
                pend_next  = '{status: ST_RANGE, page_out: '0, released: 1'b0,
                               count_after: '0};
                pend_load  = 1'b1;
                state_next = S_REPLY;
              end else begin
                cnt_re     = 1'b1;
                state_next = S_RMW;
              end
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        // One count cleared and, inside the range, one page pushed per cycle.
        cnt_we = 1'b1;
        stk_we = (sweep_c >= first_c) && (sweep_c < top_c);
        if (sweep == LAST_PAGE) begin
          if (slot_free) begin
            out_load   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      S_POP: begin
        if (slot_free) begin
          cnt_we    = 1'b1;
          cnt_waddr = stk_rdata;
          cnt_wdata = COUNT_BITS'(1);
          out_next.page_out    = got_x[PAGE_W-1:0];
          out_next.count_after = COUNT_OUT_W'(1);
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RMW: begin
        if (slot_free) begin
          cnt_waddr = op_idx;
          stk_waddr = depth[PB-1:0];
          stk_wdata = op_idx;
          if (op_kind == KIND_FREE) begin
            if (cnt_rdata == '0) begin
              out_next.status = ST_NOT_ALLOC;
            end else begin
              cnt_new   = cnt_rdata - 1'b1;
              cnt_we    = 1'b1;
              cnt_wdata = cnt_new;
              if (cnt_new == '0 && depth != DEPTH_MAX) begin
                stk_we            = 1'b1;
                depth_next        = depth + 1'b1;
                out_next.released = 1'b1;
              end
            end
          end else begin
            if (cnt_rdata == CNT_MAX) begin
              out_next.status = ST_OVERFLOW;
            end else begin
              cnt_new   = cnt_rdata + 1'b1;
              cnt_we    = 1'b1;
              cnt_wdata = cnt_new;
            end
          end
          cnt_x                = CXW'(cnt_new);
          out_next.count_after = cnt_x[COUNT_OUT_W-1:0];
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REPLY: begin
        if (slot_free) begin
          out_next   = pend;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      depth <= '0;
      sweep <= '0;
    end else begin
      state <= state_next;
      depth <= depth_next;
      sweep <= sweep_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      op_kind <= kind_t'(kind);
      op_idx  <= pg_idx;
    end
    if (pend_load) begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= out_next;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_MAX)
    else $error("free stack depth beyond page count");

  a_pop_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid && kind_t'(kind) == KIND_ALLOC && depth != '0)
    |=> (depth == $past(depth) - 1'b1) && state == S_POP)
    else $error("allocate did not pop the stack");

  a_release_push: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_next.released) |-> (stk_we && state == S_RMW))
    else $error("release reported without a push");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(rsp_valid && rsp_stall))
    else $error("result register overwritten while stalled");

endmodule

>>> hw/rtl/refcounted_page_frame_allocator.sv
// Reference-counted page frame allocator. Requests carry an operation kind
// (init, allocate, free, add reference) and a page number; every request
// gives exactly one response with status, allocated page, released flag and
// the page's count afterwards. Allocate, free and add reference issue a read
// of the count store or the free stack in the request cycle; the following
// state (pop or read-modify-write) uses the registered read data and writes
// back once the output register is free. No new request is taken until the
// sequencer is idle again. Out-of-memory and out-of-range answers pass
// through a reply state instead. Init sweeps every count entry to zero,
// one per cycle, while pushing the pages from first_page up to end_page
// (capped at PAGE_COUNT) onto the stack in ascending order; no request is
// taken during the sweep. Counts are undefined until the first init. A
// response waits in an output register, so the sequencer finishes an
// operation as soon as the previous response has been taken. Configuration
// must be written only while the block is idle, which is not enforced.
//
// Depends on rpfa_pkg, rpfa_ram and rpfa_ctrl.
module refcounted_page_frame_allocator #(
  parameter int PAGE_COUNT = rpfa_pkg::PAGE_COUNT_DEF,
  parameter int COUNT_BITS = rpfa_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rpfa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [rpfa_pkg::KIND_W-1:0]       kind,
  input  logic [rpfa_pkg::PAGE_W-1:0]       page_number,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [rpfa_pkg::STATUS_W-1:0]     status,
  output logic [rpfa_pkg::PAGE_W-1:0]       page_out,
  output logic                              released,
  output logic [rpfa_pkg::COUNT_OUT_W-1:0]  count_after
);
  import rpfa_pkg::*;

  localparam int PB = $clog2(PAGE_COUNT);

  result_t               rsp;
  logic                  cnt_we, cnt_re, stk_we, stk_re;
  logic [PB-1:0]         cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic [PB-1:0]         stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  // The sequencer holds all control; the two memories hold the state.
  rpfa_ctrl #(
    .PAGE_COUNT (PAGE_COUNT),
    .COUNT_BITS (COUNT_BITS),
    .PB         (PB)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .kind        (kind),
    .page_number (page_number),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cnt_we      (cnt_we),
    .cnt_waddr   (cnt_waddr),
    .cnt_wdata   (cnt_wdata),
    .cnt_re      (cnt_re),
    .cnt_raddr   (cnt_raddr),
    .cnt_rdata   (cnt_rdata),
    .stk_we      (stk_we),
    .stk_waddr   (stk_waddr),
    .stk_wdata   (stk_wdata),
    .stk_re      (stk_re),
    .stk_raddr   (stk_raddr),
    .stk_rdata   (stk_rdata)
  );

  // One reference count per page frame.
  rpfa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (PAGE_COUNT),
    .AW    (PB)
  ) u_count_mem (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Last-in-first-out stack of free page numbers.
  rpfa_ram #(
    .WIDTH (PB),
    .DEPTH (PAGE_COUNT),
    .AW    (PB)
  ) u_stack_mem (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign status      = rsp.status;
  assign page_out    = rsp.page_out;
  assign released    = rsp.released;
  assign count_after = rsp.count_after;

endmodule
